[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define KDJ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition must never be true outside reset.
`define KDJ_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define KDJ_ASSERT(lbl, clk, rst_n, prop)
`define KDJ_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hw/rtl/kdj_pkg.sv]
package kdj_pkg;
	localparam int WINDOW_MAX = 64;
	localparam int ROW_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = ROW_W + 1;
	localparam int PRICE_W = 32;
	localparam int RSV_W = 23;
	localparam int J_W = 26;
	localparam int ALPHA_W = 25;
	localparam int DIV_Q_W = 25;
	localparam int DIV_D_W = PRICE_W;
	localparam int DIV_N_W = DIV_D_W + DIV_Q_W;
	localparam int ACC_W = 50;

	localparam logic [ALPHA_W-1:0] ONE_Q24 = 25'h1000000;
	localparam logic [RSV_W-1:0] RSV_FULL = 23'd6553600;

	localparam logic [1:0] CFG_WINDOW = 2'd0;
	localparam logic [1:0] CFG_KPER = 2'd1;
	localparam logic [1:0] CFG_DPER = 2'd2;

	// One classified bar, handed from the front to the back.
	typedef struct packed {
		logic first_bar;
		logic rsv_ok;
		logic [PRICE_W-1:0] num;
		logic [PRICE_W-1:0] range;
	} kdj_item_t;

	typedef struct packed {
		logic start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} kdj_div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_Q_W-1:0] quotient;
	} kdj_div_rsp_t;
endpackage

[hw/rtl/kdj_div.sv]
module kdj_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kdj_pkg::kdj_div_req_t req,
	output kdj_pkg::kdj_div_rsp_t rsp
);
	import kdj_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] step_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_D_W:0] trial;
	logic ge;

	assign trial = {rem_q, low_q[DIV_Q_W-1]};
	assign ge = trial >= {1'b0, dsr_q};

	// Restoring division, one quotient bit per cycle. The quotient always fits
	// in DIV_Q_W bits, so the upper dividend bits start out below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
			low_q <= '0;
			quo_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					step_q <= '0;
					rem_q <= req.dividend[DIV_N_W-1:DIV_Q_W];
					low_q <= req.dividend[DIV_Q_W-1:0];
					dsr_q <= req.divisor;
				end
			end else begin
				rem_q <= ge ? DIV_D_W'(trial - {1'b0, dsr_q}) : trial[DIV_D_W-1:0];
				low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
				quo_q <= {quo_q[DIV_Q_W-2:0], ge};
				step_q <= step_q + 5'd1;
				if (step_q == 5'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

[hw/rtl/kdj_front.sv]
module kdj_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      first_bar,
	input  logic [kdj_pkg::PRICE_W-1:0] high_price,
	input  logic [kdj_pkg::PRICE_W-1:0] low_price,
	input  logic [kdj_pkg::PRICE_W-1:0] close_price,
	input  logic [kdj_pkg::CNT_W-1:0]   win,
	output kdj_pkg::kdj_item_t        item,
	output logic                      item_push,
	input  logic                      item_full
);
	import kdj_pkg::*;

	localparam int ENTRY_W = ROW_W + PRICE_W;

	typedef enum logic [2:0] {
		S_IDLE, S_EXP_RD, S_EXP_CHK, S_POP_RD, S_POP_CHK, S_PUSH, S_HEAD_RD, S_EMIT
	} state_t;

	state_t state_q;
	logic sel_q;
	logic [ROW_W-1:0] head_min_q, head_max_q, cur_row_q;
	logic [CNT_W-1:0] cnt_min_q, cnt_max_q, bar_cnt_q;
	logic [PRICE_W-1:0] hi_q, lo_q, cl_q;
	logic first_q;

	logic [ENTRY_W-1:0] min_mem [WINDOW_MAX];
	logic [ENTRY_W-1:0] max_mem [WINDOW_MAX];
	logic [ENTRY_W-1:0] min_rd_q, max_rd_q;

	logic [ROW_W-1:0] cur_head, back_addr, wr_addr, min_raddr, max_raddr, rd_row;
	logic [CNT_W-1:0] cur_cnt, age, bc_clamp, bc_next;
	logic [ENTRY_W-1:0] cur_rd, wr_data;
	logic [PRICE_W-1:0] push_val, rd_val, mn, mx, cl_sat;
	logic drop, min_we, max_we, rsv_ok, head_sel;

	assign cur_head = sel_q ? head_max_q : head_min_q;
	assign cur_cnt = sel_q ? cnt_max_q : cnt_min_q;
	assign cur_rd = sel_q ? max_rd_q : min_rd_q;
	assign push_val = sel_q ? hi_q : lo_q;
	assign rd_row = cur_rd[ENTRY_W-1:PRICE_W];
	assign rd_val = cur_rd[PRICE_W-1:0];
	assign back_addr = ROW_W'(cur_head + cur_cnt[ROW_W-1:0] - 1'b1);
	assign wr_addr = ROW_W'(cur_head + cur_cnt[ROW_W-1:0]);
	assign wr_data = {cur_row_q, push_val};
	// Both heads stay addressed while the finished bar waits to be handed over.
	assign head_sel = (state_q == S_HEAD_RD) || (state_q == S_EMIT);
	assign min_raddr = head_sel ? head_min_q :
		(state_q == S_POP_RD) ? back_addr : cur_head;
	assign max_raddr = head_sel ? head_max_q :
		(state_q == S_POP_RD) ? back_addr : cur_head;
	assign min_we = (state_q == S_PUSH) && !sel_q;
	assign max_we = (state_q == S_PUSH) && sel_q;

	// Age of the stored row seen from the incoming bar, 1 to WINDOW_MAX.
	assign age = {1'b0, ROW_W'(cur_row_q - rd_row - 1'b1)} + 1'b1;
	assign drop = sel_q ? (rd_val <= push_val) : (rd_val >= push_val);

	assign mn = min_rd_q[PRICE_W-1:0];
	assign mx = max_rd_q[PRICE_W-1:0];
	assign bc_clamp = (bar_cnt_q > win) ? win : bar_cnt_q;
	assign bc_next = (bc_clamp < win) ? bc_clamp + 1'b1 : bc_clamp;
	assign rsv_ok = (bc_next == win) && (mx > mn);
	assign cl_sat = (cl_q < mn) ? mn : ((cl_q > mx) ? mx : cl_q);

	assign item.first_bar = first_q;
	assign item.rsv_ok = rsv_ok;
	assign item.num = cl_sat - mn;
	assign item.range = mx - mn;
	assign item_push = (state_q == S_EMIT) && !item_full;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (min_we) begin
			min_mem[wr_addr] <= wr_data;
		end
		if (max_we) begin
			max_mem[wr_addr] <= wr_data;
		end
		min_rd_q <= min_mem[min_raddr];
		max_rd_q <= max_mem[max_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= 1'b0;
			head_min_q <= '0;
			head_max_q <= '0;
			cnt_min_q <= '0;
			cnt_max_q <= '0;
			cur_row_q <= '0;
			bar_cnt_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			cl_q <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						hi_q <= high_price;
						lo_q <= low_price;
						cl_q <= close_price;
						first_q <= first_bar;
						sel_q <= 1'b0;
						if (first_bar) begin
							head_min_q <= '0;
							head_max_q <= '0;
							cnt_min_q <= '0;
							cnt_max_q <= '0;
							cur_row_q <= '0;
							bar_cnt_q <= '0;
						end
						state_q <= S_EXP_RD;
					end
				end
				S_EXP_RD: begin
					state_q <= (cur_cnt == '0) ? S_POP_RD : S_EXP_CHK;
				end
				S_EXP_CHK: begin
					if (age >= win) begin
						if (sel_q) begin
							head_max_q <= head_max_q + 1'b1;
							cnt_max_q <= cnt_max_q - 1'b1;
						end else begin
							head_min_q <= head_min_q + 1'b1;
							cnt_min_q <= cnt_min_q - 1'b1;
						end
						state_q <= S_EXP_RD;
					end else begin
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					state_q <= (cur_cnt == '0) ? S_PUSH : S_POP_CHK;
				end
				S_POP_CHK: begin
					if (drop) begin
						if (sel_q) begin
							cnt_max_q <= cnt_max_q - 1'b1;
						end else begin
							cnt_min_q <= cnt_min_q - 1'b1;
						end
						state_q <= S_POP_RD;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sel_q) begin
						cnt_max_q <= cnt_max_q + 1'b1;
						state_q <= S_HEAD_RD;
					end else begin
						cnt_min_q <= cnt_min_q + 1'b1;
						sel_q <= 1'b1;
						state_q <= S_EXP_RD;
					end
				end
				S_HEAD_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!item_full) begin
						bar_cnt_q <= bc_next;
						cur_row_q <= cur_row_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[hw/rtl/kdj_fifo.sv]
module kdj_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kdj_pkg::kdj_item_t din,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output kdj_pkg::kdj_item_t dout
);
	import kdj_pkg::*;

	kdj_item_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign dout = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end
endmodule

[hw/rtl/kdj_back.sv]
module kdj_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kdj_pkg::kdj_item_t        item,
	input  logic                      item_valid,
	output logic                      item_pop,
	input  logic [7:0]                k_period,
	input  logic [7:0]                d_period,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [kdj_pkg::RSV_W-1:0] rsv_value,
	output logic                      rsv_valid,
	output logic [kdj_pkg::RSV_W-1:0] k_value,
	output logic [kdj_pkg::RSV_W-1:0] d_value,
	output logic signed [kdj_pkg::J_W-1:0] j_value,
	output logic                      kdj_valid
);
	import kdj_pkg::*;

	localparam int NUM_W = PRICE_W + 7;

	typedef enum logic [4:0] {
		B_IDLE, B_KA_GO, B_KA_WT, B_KD_GO, B_KD_WT, B_RSV_GO, B_RSV_WT, B_DECAY,
		B_KM1, B_KM2, B_KDIV_GO, B_KDIV_WT, B_DM1, B_DM2, B_DUPD, B_OUT
	} state_t;

	state_t state_q;
	kdj_item_t item_q;
	logic [ALPHA_W-1:0] ka_q, kd_q, w_q;
	logic [RSV_W-1:0] rsv_q, k_q, d_q;
	logic started_q;
	logic [ACC_W-1:0] acc_q;

	logic out_valid_q, rsv_valid_q, kdj_valid_q;
	logic [RSV_W-1:0] rsv_out_q, k_out_q, d_out_q;
	logic [J_W-1:0] j_out_q;

	kdj_div_req_t dreq;
	kdj_div_rsp_t drsp;
	logic [ALPHA_W-1:0] mul_a, mul_b;
	logic [ACC_W-1:0] prod;
	logic [7:0] kp_eff, dp_eff;
	logic [NUM_W-1:0] num_x100;
	logic [J_W-1:0] j_calc;

	kdj_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	assign kp_eff = (k_period == 8'd0) ? 8'd1 : k_period;
	assign dp_eff = (d_period == 8'd0) ? 8'd1 : d_period;
	assign num_x100 = NUM_W'(item_q.num) * NUM_W'(100);

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = DIV_N_W'(ONE_Q24);
		dreq.divisor = DIV_D_W'(kp_eff);
		case (state_q)
			B_KA_GO: begin
				dreq.start = 1'b1;
			end
			B_KD_GO: begin
				dreq.start = 1'b1;
				dreq.divisor = DIV_D_W'(dp_eff);
			end
			B_RSV_GO: begin
				dreq.start = 1'b1;
				dreq.dividend = DIV_N_W'({num_x100, 16'b0});
				dreq.divisor = item_q.range;
			end
			B_KDIV_GO: begin
				dreq.start = 1'b1;
				dreq.dividend = DIV_N_W'(acc_q);
				dreq.divisor = DIV_D_W'({1'b0, w_q} + {1'b0, ka_q});
			end
			default: begin
			end
		endcase
	end

	// One shared multiplier; its product is always registered before use.
	always_comb begin
		case (state_q)
			B_DECAY: begin
				mul_a = w_q;
				mul_b = ONE_Q24 - ka_q;
			end
			B_KM1: begin
				mul_a = w_q;
				mul_b = ALPHA_W'(k_q);
			end
			B_KM2: begin
				mul_a = ka_q;
				mul_b = ALPHA_W'(rsv_q);
			end
			B_DM1: begin
				mul_a = ONE_Q24 - kd_q;
				mul_b = ALPHA_W'(d_q);
			end
			default: begin
				mul_a = kd_q;
				mul_b = ALPHA_W'(k_q);
			end
		endcase
	end
	assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

	assign j_calc = J_W'(J_W'(k_q) * J_W'(3)) - J_W'(J_W'(d_q) * J_W'(2));
	assign item_pop = (state_q == B_IDLE) && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			item_q <= '0;
			ka_q <= '0;
			kd_q <= '0;
			w_q <= ONE_Q24;
			rsv_q <= '0;
			k_q <= '0;
			d_q <= '0;
			started_q <= 1'b0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			rsv_valid_q <= 1'b0;
			kdj_valid_q <= 1'b0;
			rsv_out_q <= '0;
			k_out_q <= '0;
			d_out_q <= '0;
			j_out_q <= '0;
		end else begin
			// In B_OUT the result register is either kept or reloaded below.
			if (out_valid_q && !out_stall && (state_q != B_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						if (item.first_bar) begin
							k_q <= '0;
							d_q <= '0;
							w_q <= ONE_Q24;
							started_q <= 1'b0;
						end
						state_q <= B_KA_GO;
					end
				end
				B_KA_GO: state_q <= B_KA_WT;
				B_KA_WT: begin
					if (drsp.done) begin
						ka_q <= drsp.quotient;
						state_q <= B_KD_GO;
					end
				end
				B_KD_GO: state_q <= B_KD_WT;
				B_KD_WT: begin
					if (drsp.done) begin
						kd_q <= drsp.quotient;
						if (item_q.rsv_ok) begin
							state_q <= B_RSV_GO;
						end else begin
							rsv_q <= '0;
							state_q <= B_DECAY;
						end
					end
				end
				B_RSV_GO: state_q <= B_RSV_WT;
				B_RSV_WT: begin
					if (drsp.done) begin
						rsv_q <= RSV_W'(drsp.quotient);
						state_q <= B_DECAY;
					end
				end
				B_DECAY: begin
					if (started_q) begin
						w_q <= prod[24 +: ALPHA_W];
					end
					if (item_q.rsv_ok) begin
						if (!started_q) begin
							k_q <= rsv_q;
							d_q <= rsv_q;
							started_q <= 1'b1;
							w_q <= ONE_Q24;
							state_q <= B_OUT;
						end else begin
							state_q <= B_KM1;
						end
					end else begin
						state_q <= started_q ? B_DM1 : B_OUT;
					end
				end
				B_KM1: begin
					acc_q <= prod;
					state_q <= B_KM2;
				end
				B_KM2: begin
					acc_q <= acc_q + prod;
					state_q <= B_KDIV_GO;
				end
				B_KDIV_GO: state_q <= B_KDIV_WT;
				B_KDIV_WT: begin
					if (drsp.done) begin
						k_q <= RSV_W'(drsp.quotient);
						w_q <= ONE_Q24;
						state_q <= B_DM1;
					end
				end
				B_DM1: begin
					acc_q <= prod;
					state_q <= B_DM2;
				end
				B_DM2: begin
					acc_q <= acc_q + prod;
					state_q <= B_DUPD;
				end
				B_DUPD: begin
					d_q <= acc_q[24 +: RSV_W];
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						rsv_out_q <= rsv_q;
						rsv_valid_q <= item_q.rsv_ok;
						kdj_valid_q <= started_q;
						k_out_q <= started_q ? k_q : '0;
						d_out_q <= started_q ? d_q : '0;
						j_out_q <= started_q ? j_calc : '0;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign rsv_value = rsv_out_q;
	assign rsv_valid = rsv_valid_q;
	assign k_value = k_out_q;
	assign d_value = d_out_q;
	assign j_value = signed'(j_out_q);
	assign kdj_valid = kdj_valid_q;
endmodule

[hw/rtl/kdj_stochastic_oscillator_unit.sv]
// KDJ stochastic oscillator: one price bar in, one K/D/J result out.
// Input channel: in_valid with first_bar, high_price, low_price and close_price;
// a request is taken at a clock edge where in_valid is high and in_stall is low.
// first_bar clears the rolling window and the averages before that bar.
// Output channel: out_valid with rsv_value, rsv_valid, k_value, d_value,
// j_value and kdj_valid; a request is delivered when out_valid is high and
// out_stall is low. Every bar yields exactly one result, in order.
// The front walks the min and max monotonic queues in block RAM: for each queue
// it expires old head entries, drops displaced back entries, then pushes the bar.
// The back runs on one shared 25-step divider for the K and D weights, the RSV
// and the K update; a bar without a valid RSV skips the RSV division, and only
// a valid RSV that updates a running K needs the K division. The back sets the
// throughput; a two-entry queue between front and back lets the front take the
// next bar meanwhile.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data)
// only while idle; the block itself does not enforce this.
// After reset the window is 9 bars and both periods are 3; all state is clear.
// A stalled result holds in the output register while the back may start the
// next bar from the queue; only then does back pressure reach in_stall.
`include "assert_macros.svh"
module kdj_stochastic_oscillator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [7:0]                cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      first_bar,
	input  logic [kdj_pkg::PRICE_W-1:0] high_price,
	input  logic [kdj_pkg::PRICE_W-1:0] low_price,
	input  logic [kdj_pkg::PRICE_W-1:0] close_price,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [kdj_pkg::RSV_W-1:0] rsv_value,
	output logic                      rsv_valid,
	output logic [kdj_pkg::RSV_W-1:0] k_value,
	output logic [kdj_pkg::RSV_W-1:0] d_value,
	output logic signed [kdj_pkg::J_W-1:0] j_value,
	output logic                      kdj_valid
);
	import kdj_pkg::*;

	logic [CNT_W-1:0] window_q, win_eff;
	logic [7:0] kper_q, dper_q;
	kdj_item_t push_item, pop_item;
	logic item_push, item_full, item_pop, item_valid;

	// Configuration registers. Unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 7'd9;
			kper_q <= 8'd3;
			dper_q <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW: window_q <= cfg_data[CNT_W-1:0];
				CFG_KPER: kper_q <= cfg_data;
				CFG_DPER: dper_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A zero window acts as one bar, and the window never exceeds the queue depth.
	assign win_eff = (window_q == '0) ? 7'd1 :
		((window_q > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : window_q);

	kdj_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_bar  (first_bar),
		.high_price (high_price),
		.low_price  (low_price),
		.close_price(close_price),
		.win        (win_eff),
		.item       (push_item),
		.item_push  (item_push),
		.item_full  (item_full)
	);

	kdj_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (item_push),
		.din      (push_item),
		.full     (item_full),
		.pop      (item_pop),
		.not_empty(item_valid),
		.dout     (pop_item)
	);

	kdj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (pop_item),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.k_period  (kper_q),
		.d_period  (dper_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rsv_value (rsv_value),
		.rsv_valid (rsv_valid),
		.k_value   (k_value),
		.d_value   (d_value),
		.j_value   (j_value),
		.kdj_valid (kdj_valid)
	);

	// The front never hands over a bar when the queue has no room.
	`KDJ_NEVER(a_queue_overflow, clk, arst_n, item_push && item_full)
	// Once a bar is handed over, the front is ready for the next one.
	`KDJ_ASSERT(a_front_ready, clk, arst_n, item_push |=> !in_stall)
	// RSV stays within 0 to 100.
	`KDJ_ASSERT(a_rsv_range, clk, arst_n, out_valid && rsv_valid |-> rsv_value <= RSV_FULL)
	// Before K starts, the averages read as zero.
	`KDJ_ASSERT(a_kdj_zero, clk, arst_n, out_valid && !kdj_valid |-> k_value == '0 && d_value == '0)
endmodule

[test/kdj_checker.sv]
module kdj_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              first_bar,
	input  logic [kdj_pkg::PRICE_W-1:0]       high_price,
	input  logic [kdj_pkg::PRICE_W-1:0]       low_price,
	input  logic [kdj_pkg::PRICE_W-1:0]       close_price,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [kdj_pkg::RSV_W-1:0]         rsv_value,
	input  logic                              rsv_valid,
	input  logic [kdj_pkg::RSV_W-1:0]         k_value,
	input  logic [kdj_pkg::RSV_W-1:0]         d_value,
	input  logic signed [kdj_pkg::J_W-1:0]    j_value,
	input  logic                              kdj_valid,
	output int                                fail_count,
	output int                                pending_bars,
	output int                                bars_accepted,
	output int                                valid_rsv_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import kdj_pkg::*;

	typedef struct {
		logic [RSV_W-1:0] rsv;
		logic             rsv_ok;
		logic [RSV_W-1:0] k;
		logic [RSV_W-1:0] d;
		logic [J_W-1:0]   j;
		logic             kdj_ok;
	} kdj_result_t;

	kdj_result_t expected_results[$];

	// Predictor state: monotonic queues kept as SV queues of (price, row).
	logic [31:0] lo_val[$], hi_val[$];
	int          lo_row[$], hi_row[$];
	int          row_ctr, bar_fill;
	logic [63:0] k_avg, d_avg, k_wt;
	bit          k_on;
	int          win_reg, kper_reg, dper_reg;

	function automatic int age_of(int r);
		return ((row_ctr + WINDOW_MAX - r - 1) % WINDOW_MAX) + 1;
	endfunction

	function automatic logic [63:0] rsv_ratio(logic [63:0] num, logic [63:0] range);
		logic [63:0] q, r;
		q = (num * 100) / range;
		r = (num * 100) % range;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= range) begin
				r = r - range;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	task automatic clear_series();
		lo_val.delete(); hi_val.delete(); lo_row.delete(); hi_row.delete();
		row_ctr = 0;
		bar_fill = 0;
		k_avg = 0;
		d_avg = 0;
		k_wt = 64'(ONE_Q24);
		k_on = 0;
	endtask

	task automatic predict_bar(logic fb, logic [31:0] hi, logic [31:0] lo, logic [31:0] cl);
		int w;
		logic [63:0] mn, mx, rsv, ka, kd, c;
		bit ok;
		kdj_result_t e;
		if (fb)
			clear_series();
		w = win_reg == 0 ? 1 : (win_reg > WINDOW_MAX ? WINDOW_MAX : win_reg);
		while (lo_val.size() > 0 && age_of(lo_row[0]) >= w) begin
			lo_val.delete(0); lo_row.delete(0);
		end
		while (hi_val.size() > 0 && age_of(hi_row[0]) >= w) begin
			hi_val.delete(0); hi_row.delete(0);
		end
		while (lo_val.size() > 0 && lo_val[$] >= lo) begin
			lo_val.delete(lo_val.size() - 1); lo_row.delete(lo_row.size() - 1);
		end
		while (hi_val.size() > 0 && hi_val[$] <= hi) begin
			hi_val.delete(hi_val.size() - 1); hi_row.delete(hi_row.size() - 1);
		end
		lo_val.insert(lo_val.size(), lo); lo_row.insert(lo_row.size(), row_ctr);
		hi_val.insert(hi_val.size(), hi); hi_row.insert(hi_row.size(), row_ctr);
		mn = lo_val[0];
		mx = hi_val[0];
		row_ctr = (row_ctr + 1) % WINDOW_MAX;
		if (bar_fill > w)
			bar_fill = w;
		if (bar_fill < w)
			bar_fill++;
		rsv = 0;
		ok = 0;
		if (bar_fill >= w && mx > mn) begin
			c = cl < mn ? mn : (cl > mx ? mx : 64'(cl));
			rsv = rsv_ratio(c - mn, mx - mn);
			ok = 1;
		end
		ka = 64'(ONE_Q24) / (kper_reg == 0 ? 1 : kper_reg);
		kd = 64'(ONE_Q24) / (dper_reg == 0 ? 1 : dper_reg);
		if (k_on)
			k_wt = (k_wt * (64'(ONE_Q24) - ka)) >> 24;
		if (ok) begin
			if (!k_on) begin
				k_avg = rsv;
				d_avg = rsv;
				k_on = 1;
			end else begin
				k_avg = (k_wt * k_avg + ka * rsv) / (k_wt + ka);
				d_avg = ((64'(ONE_Q24) - kd) * d_avg + kd * k_avg) >> 24;
			end
			k_wt = 64'(ONE_Q24);
		end else if (k_on) begin
			d_avg = ((64'(ONE_Q24) - kd) * d_avg + kd * k_avg) >> 24;
		end
		e.rsv = rsv[RSV_W-1:0];
		e.rsv_ok = ok;
		e.k = k_on ? k_avg[RSV_W-1:0] : '0;
		e.d = k_on ? d_avg[RSV_W-1:0] : '0;
		e.j = k_on ? J_W'(3 * k_avg - 2 * d_avg) : '0;
		e.kdj_ok = k_on;
		expected_results.insert(expected_results.size(), e);
	endtask

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		kdj_result_t e;
		if (!arst_n) begin
			clear_series();
			win_reg = 9;
			kper_reg = 3;
			dper_reg = 3;
			fail_count = 0;
			bars_accepted = 0;
			valid_rsv_seen = 0;
			expected_results.delete();
			pending_bars = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW: win_reg = cfg_data & 8'h7f;
					CFG_KPER: kper_reg = cfg_data;
					CFG_DPER: dper_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_bar(first_bar, high_price, low_price, close_price);
				bars_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no bar outstanding");
					fail_count++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					if (rsv_valid)
						valid_rsv_seen++;
					compare_field("rsv_value", e.rsv, rsv_value);
					compare_field("rsv_valid", e.rsv_ok, rsv_valid);
					compare_field("k_value", e.k, k_value);
					compare_field("d_value", e.d, d_value);
					compare_field("j_value", e.j, unsigned'(j_value));
					compare_field("kdj_valid", e.kdj_ok, kdj_valid);
				end
			end
			pending_bars = expected_results.size();
		end
	end
endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kdj_pkg::*;

	// The watchdog allows for the slowest result and a long output stall on top of
	// that, many times over.
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_WINDOW;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic first_bar = 1'b0;
	logic [PRICE_W-1:0] high_price = '0, low_price = '0, close_price = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [RSV_W-1:0] rsv_value, k_value, d_value;
	logic rsv_valid, kdj_valid;
	logic signed [J_W-1:0] j_value;
	int fail_count, pending_bars, bars_accepted, valid_rsv_seen;
	int idle_cycles = 0;
	bit stall_enable = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	kdj_stochastic_oscillator_unit i_dut (.*);

	kdj_checker i_checker (.*);

	// The watchdog counts cycles where neither channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Gap lengths: mostly short, an occasional long one.
	function automatic int gap_length();
		if ($urandom_range(9) == 0)
			return $urandom_range(400, 60);
		else if ($urandom_range(2) == 0)
			return 0;
		else
			return $urandom_range(5, 1);
	endfunction

	// The receiver stalls in random bursts, and stays open for stretches.
	always begin
		int n;
		@(negedge clk);
		n = gap_length();
		out_stall <= stall_enable && n > 0;
		repeat (n > 0 ? n : $urandom_range(30, 1)) @(negedge clk);
		out_stall <= 1'b0;
		repeat ($urandom_range(40, 1)) @(negedge clk);
	end

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait until every result is back, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_bars != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Present one request and hold it until the block takes it. Valid stays
	// high afterwards so that a following request can come back to back.
	task automatic send_bar(logic fb, logic [31:0] hi, logic [31:0] lo, logic [31:0] cl,
			bit with_gap);
		int g;
		g = with_gap ? gap_length() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		first_bar <= fb;
		high_price <= hi;
		low_price <= lo;
		close_price <= cl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A random walk of prices; high, low and close form a sensible bar
	// most of the time, with occasional inverted or out-of-range bars.
	task automatic random_series(int bars, bit wide, bit restart);
		logic [31:0] base, hi, lo, cl, span;
		base = wide ? $urandom : $urandom_range(5000, 100);
		for (int i = 0; i < bars; i++) begin
			span = wide ? $urandom : $urandom_range(50);
			if ($urandom_range(3) == 0)
				base = base + $urandom_range(40) - 20;
			lo = base;
			hi = base + span;
			cl = lo + (span == 0 ? 0 : $urandom_range(span));
			case ($urandom_range(15))
				0: begin hi = $urandom; lo = $urandom; end
				1: cl = $urandom;
				2: cl = 0;
				3: hi = lo;
				default: ;
			endcase
			send_bar((i == 0 && restart) || $urandom_range(60) == 0, hi, lo, cl, 1'b1);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed bars at reset settings: extremes, flat and inverted ranges,
		// closes beyond both ends, and a restart on the last bar.
		send_bar(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
		send_bar(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
		for (int i = 0; i < 8; i++)
			send_bar(1'b0, 32'd200 + i, 32'd100, 32'd150, 1'b0);
		send_bar(1'b0, 32'd300, 32'd50, 32'hFFFF_FFFF, 1'b0);
		send_bar(1'b0, 32'd300, 32'd50, 32'd0, 1'b0);
		send_bar(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_bar(1'b1, 32'd10, 32'd10, 32'd10, 1'b0);
		drain();

		// Window of one: range is always the single bar; shortest periods.
		write_reg(CFG_WINDOW, 8'd1);
		write_reg(CFG_KPER, 8'd1);
		write_reg(CFG_DPER, 8'd1);
		send_bar(1'b1, 32'd20, 32'd10, 32'd15, 1'b0);
		send_bar(1'b0, 32'd20, 32'd20, 32'd20, 1'b0);
		send_bar(1'b0, 32'hFFFF_FFFF, 32'd0, 32'h5555_5555, 1'b0);
		drain();

		// Eight phases of random bars; after each the sender waits for every result.
		for (int phase = 0; phase < 8; phase++) begin
			logic [7:0] w, kp, dp;
			case (phase)
				0: begin w = 8'd64; kp = 8'd255; dp = 8'd255; end
				1: begin w = 8'd0; kp = 8'd0; dp = 8'd0; end
				2: begin w = 8'd127; kp = 8'd2; dp = 8'd9; end
				default: begin
					w = 8'($urandom_range(20, 2));
					kp = 8'($urandom_range(12, 1));
					dp = 8'($urandom_range(12, 1));
				end
			endcase
			write_reg(CFG_WINDOW, w);
			write_reg(CFG_KPER, kp);
			write_reg(CFG_DPER, dp);
			stall_enable = phase != 3;
			random_series(phase < 3 ? 90 : 150, phase == 4, 1'b1);
			// Shrink the window mid-series without a restart once.
			if (phase == 5) begin
				drain();
				write_reg(CFG_WINDOW, 8'd3);
				random_series(40, 1'b0, 1'b0);
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d bars, %0d with a valid RSV, over eleven register settings.",
			bars_accepted, valid_rsv_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
